/* rtl/mrcm_pkg.sv */
package mrcm_pkg;

  // Default build: four table entries, 24-bit coordinates
  localparam int unsigned PanelsDef    = 4;
  localparam int unsigned CoordBitsDef = 24;

  // Opcodes carried in the input tuser
  typedef enum logic [1:0] {
    OP_LOAD_PHYS     = 2'd0,
    OP_LOAD_LOGIC    = 2'd1,
    OP_PHYS_TO_LOGIC = 2'd2,
    OP_LOGIC_TO_PHYS = 2'd3
  } op_e;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_B_RD,
    ST_B_CLAMP,
    ST_B_SQX,
    ST_B_SQY,
    ST_B_CMP,
    ST_C_RD,
    ST_C_CHK,
    ST_SEL_RD,
    ST_SEL_OFF,
    ST_MULX,
    ST_MULY,
    ST_DIV_GO,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_e;

endpackage

/* rtl/mrcm_div.sv */
module mrcm_div #(
  parameter int unsigned NUM_W = 46,
  parameter int unsigned DEN_W = 23
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quot_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  // One quotient bit per cycle, restoring
  assign trial = {rem_q, quot_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};

  // Control: busy over NUM_W steps, one-cycle done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath: shift in dividend, subtract when the trial remainder fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      if (!diff[DEN_W]) begin
        rem_q  <= diff[DEN_W-1:0];
        quot_q <= {quot_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q  <= trial[DEN_W-1:0];
        quot_q <= {quot_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/multi_rect_coordinate_mapper_top.sv */
// Panel coordinate mapper. Loads (opcodes 0 and 1) go straight to the output state, and so
// does any query while no entry is in use. A logical to physical query walks the logical
// table and runs the scale step when an entry holds the point. A physical to logical query
// walks the physical table; if no entry holds the point it clamps the point onto the nearest
// entry and walks again for the entry holding it, before the scale step. The table walks
// read the on-chip entry memories one entry at a time, and the scale step is set by two
// bit-serial dividers running side by side, one quotient bit a cycle. One item is in work
// at a time; a new item is taken while the previous result still waits in the output
// register. Entries must be loaded before a query uses them.
module multi_rect_coordinate_mapper_top #(
  parameter int unsigned PANELS     = mrcm_pkg::PanelsDef,
  parameter int unsigned COORD_BITS = mrcm_pkg::CoordBitsDef
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [2:0]                                cfg_wdata_i,   // panel_count
  input  logic                                      s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // entry_index, rect_x, rect_y, rect_w, rect_h, point_x, point_y (lowest bit up)
  input  logic [((6*COORD_BITS+7)/8)*8-1:0]         s_axis_tdata_i,
  input  logic [1:0]                                s_axis_tuser_i,  // opcode
  output logic                                      m_axis_tvalid_o,
  input  logic                                      m_axis_tready_i,
  // panel_index, mapped_x, mapped_y (lowest bit up)
  output logic [((2*COORD_BITS+2+7)/8)*8-1:0]       m_axis_tdata_o,
  output logic                                      m_axis_tuser_o   // found
);

  import mrcm_pkg::*;

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned OutW  = ((2*CB+2+7)/8)*8;
  localparam int unsigned RecW  = 4*CB - 2;
  localparam int unsigned AW    = (PANELS > 1) ? $clog2(PANELS) : 1;
  localparam int unsigned CW    = $clog2(PANELS + 1);
  localparam int unsigned SqW   = 2*CB + 2;
  localparam int unsigned ProdW = 2*CB - 2;
  localparam int unsigned SumW  = 2*CB;

  // Record layout: x, y, w, h from the lowest bit up
  function automatic logic signed [CB:0] rec_x(input logic [RecW-1:0] r);
    rec_x = {r[CB-1], r[CB-1:0]};
  endfunction

  function automatic logic signed [CB:0] rec_y(input logic [RecW-1:0] r);
    rec_y = {r[2*CB-1], r[2*CB-1:CB]};
  endfunction

  function automatic logic [CB-2:0] rec_w(input logic [RecW-1:0] r);
    rec_w = r[3*CB-2:2*CB];
  endfunction

  function automatic logic [CB-2:0] rec_h(input logic [RecW-1:0] r);
    rec_h = r[4*CB-3:3*CB-1];
  endfunction

  // Containment, half-open or closed on the far edges
  function automatic logic in_rect(input logic signed [CB:0] px, input logic signed [CB:0] py,
                                   input logic [RecW-1:0] r, input logic closed);
    logic signed [CB:0]   rx0;
    logic signed [CB:0]   ry0;
    logic signed [CB+1:0] ox;
    logic signed [CB+1:0] oy;
    logic signed [CB+1:0] ex;
    logic signed [CB+1:0] ey;
    logic signed [CB+1:0] qx;
    logic signed [CB+1:0] qy;
    rx0 = rec_x(r);
    ry0 = rec_y(r);
    ox = {rx0[CB], rx0};
    oy = {ry0[CB], ry0};
    ex = ox + $signed({3'b000, rec_w(r)});
    ey = oy + $signed({3'b000, rec_h(r)});
    qx = {px[CB], px};
    qy = {py[CB], py};
    if (qx < ox || qy < oy) begin
      in_rect = 1'b0;
    end else if (closed) begin
      in_rect = (qx <= ex) && (qy <= ey);
    end else begin
      in_rect = (qx < ex) && (qy < ey);
    end
  endfunction

  // Final value: base + quotient, rounded toward zero, saturated
  function automatic logic [CB-1:0] finish(input logic signed [CB-1:0] base,
                                           input logic [ProdW-1:0] q,
                                           input logic [CB-2:0] r);
    logic signed [SumW-1:0] s;
    logic signed [SumW-1:0] t;
    s = $signed({{(SumW-CB){base[CB-1]}}, base}) + $signed({2'b00, q});
    t = s + $signed({{(SumW-1){1'b0}}, (s[SumW-1] && (r != '0))});
    if (t[SumW-1:CB-1] == '0 || t[SumW-1:CB-1] == '1) begin
      finish = t[CB-1:0];
    end else if (t[SumW-1]) begin
      finish = {1'b1, {(CB-1){1'b0}}};
    end else begin
      finish = {1'b0, {(CB-1){1'b1}}};
    end
  endfunction

  // Register and handshake state
  state_e state_q, state_d;
  logic [2:0]  panel_count_q;
  logic        m_valid_q;
  logic [OutW-1:0] m_data_q;
  logic        m_user_q;

  // Entry memories
  logic [RecW-1:0] phys_mem  [PANELS];
  logic [RecW-1:0] logic_mem [PANELS];
  logic [RecW-1:0] phys_rd_q;
  logic [RecW-1:0] logic_rd_q;

  // Item and walk registers
  logic               dir_q;
  logic signed [CB:0] px_q, py_q;
  logic signed [CB:0] cx_q, cy_q;
  logic [AW-1:0]      ptr_q;
  logic [AW-1:0]      sel_q;
  logic [AW-1:0]      closed_i_q;
  logic               closed_hit_q;
  logic signed [CB:0] clx_q, cly_q;
  logic [CB:0]        ax_q, ay_q;
  logic [SqW-1:0]     sqx_q, sqy_q;
  logic [SqW:0]       best_q;
  logic [CB-2:0]      offx_q, offy_q, numx_q, numy_q, denx_q, deny_q;
  logic signed [CB-1:0] basex_q, basey_q;
  logic [ProdW-1:0]   prodx_q, prody_q;
  logic               res_found_q;
  logic [1:0]         res_idx_q;
  logic [CB-1:0]      res_x_q, res_y_q;

  // Combinational helpers
  logic          accept;
  logic          out_free;
  logic          div_start;
  logic          div_done_x, div_done_y;
  logic [ProdW-1:0] quot_x, quot_y;
  logic [CB-2:0] rem_x, rem_y;
  logic [CW-1:0] n_act;
  logic          last;
  logic          a_hit, c_open, c_closed;
  logic [RecW-1:0] rec_a;
  logic [RecW-1:0] rec_src, rec_dst;
  logic signed [CB:0] src_x, src_y, dst_x, dst_y;
  logic [SqW:0]  dist_sum;
  logic signed [CB:0] lo_x, lo_y, hi_x, hi_y, clx, cly;
  logic signed [CB+1:0] dx, dy;
  logic signed [CB+1:0] offx_w, offy_w;
  logic [CB-2:0] wr_w, wr_h;
  logic [AW-1:0] wr_addr;
  logic          wr_ok;
  op_e           in_op;

  // Input field slices
  logic [1:0]          in_idx;
  logic [CB-1:0]       in_rx, in_ry, in_px, in_py;
  logic [CB-2:0]       in_rw, in_rh;

  assign in_op  = op_e'(s_axis_tuser_i);
  assign in_idx = s_axis_tdata_i[1:0];
  assign in_rx  = s_axis_tdata_i[CB+1:2];
  assign in_ry  = s_axis_tdata_i[2*CB+1:CB+2];
  assign in_rw  = s_axis_tdata_i[3*CB:2*CB+2];
  assign in_rh  = s_axis_tdata_i[4*CB-1:3*CB+1];
  assign in_px  = s_axis_tdata_i[5*CB-1:4*CB];
  assign in_py  = s_axis_tdata_i[6*CB-1:5*CB];

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign n_act    = (32'(panel_count_q) > PANELS) ? CW'(PANELS) : CW'(panel_count_q);
  assign last     = (32'(ptr_q) + 32'd1) == 32'(n_act);

  // Load data: zero size acts as one LSB
  assign wr_w    = (in_rw == '0) ? (CB-1)'(1) : in_rw;
  assign wr_h    = (in_rh == '0) ? (CB-1)'(1) : in_rh;
  assign wr_addr = AW'(in_idx);
  assign wr_ok   = 32'(in_idx) < PANELS;

  // Containment checks for the walks
  assign rec_a    = dir_q ? logic_rd_q : phys_rd_q;
  assign a_hit    = in_rect(px_q, py_q, rec_a, 1'b0);
  assign c_open   = in_rect(cx_q, cy_q, phys_rd_q, 1'b0);
  assign c_closed = in_rect(cx_q, cy_q, phys_rd_q, 1'b1);

  // Clamp onto the current entry's closed rectangle
  assign lo_x = rec_x(phys_rd_q);
  assign lo_y = rec_y(phys_rd_q);
  assign hi_x = lo_x + $signed({2'b00, rec_w(phys_rd_q)});
  assign hi_y = lo_y + $signed({2'b00, rec_h(phys_rd_q)});
  assign clx  = (px_q < lo_x) ? lo_x : ((px_q > hi_x) ? hi_x : px_q);
  assign cly  = (py_q < lo_y) ? lo_y : ((py_q > hi_y) ? hi_y : py_q);
  assign dx   = {clx[CB], clx} - {px_q[CB], px_q};
  assign dy   = {cly[CB], cly} - {py_q[CB], py_q};
  assign dist_sum = {1'b0, sqx_q} + {1'b0, sqy_q};

  // Scale operands: source rectangle is the one the query point lives in
  assign rec_src = dir_q ? logic_rd_q : phys_rd_q;
  assign rec_dst = dir_q ? phys_rd_q : logic_rd_q;
  assign src_x   = rec_x(rec_src);
  assign src_y   = rec_y(rec_src);
  assign dst_x   = rec_x(rec_dst);
  assign dst_y   = rec_y(rec_dst);
  assign offx_w  = {cx_q[CB], cx_q} - {src_x[CB], src_x};
  assign offy_w  = {cy_q[CB], cy_q} - {src_y[CB], src_y};

  // Configuration and output handshake control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      panel_count_q <= '0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        panel_count_q <= cfg_wdata_i;
      end
      if (state_q == ST_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Output beat register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      m_data_q <= OutW'({res_y_q, res_x_q, res_idx_q});
      m_user_q <= res_found_q;
    end
  end

  // Entry memories: write on a load beat, read every cycle at the walk pointer
  always_ff @(posedge clk_i) begin
    if (accept && wr_ok && in_op == OP_LOAD_PHYS) begin
      phys_mem[wr_addr] <= {wr_h, wr_w, in_ry, in_rx};
    end
    if (accept && wr_ok && in_op == OP_LOAD_LOGIC) begin
      logic_mem[wr_addr] <= {wr_h, wr_w, in_ry, in_rx};
    end
    phys_rd_q  <= phys_mem[ptr_q];
    logic_rd_q <= logic_mem[ptr_q];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_LOAD_PHYS || in_op == OP_LOAD_LOGIC || n_act == '0) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_A_RD;
          end
        end
      end
      ST_A_RD:    state_d = ST_A_CHK;
      ST_A_CHK: begin
        if (a_hit) begin
          state_d = ST_SEL_RD;
        end else if (last) begin
          state_d = dir_q ? ST_OUT : ST_B_RD;
        end else begin
          state_d = ST_A_RD;
        end
      end
      ST_B_RD:    state_d = ST_B_CLAMP;
      ST_B_CLAMP: state_d = ST_B_SQX;
      ST_B_SQX:   state_d = ST_B_SQY;
      ST_B_SQY:   state_d = ST_B_CMP;
      ST_B_CMP:   state_d = last ? ST_C_RD : ST_B_RD;
      ST_C_RD:    state_d = ST_C_CHK;
      ST_C_CHK: begin
        if (c_open) begin
          state_d = ST_SEL_RD;
        end else if (last) begin
          state_d = (closed_hit_q || c_closed) ? ST_SEL_RD : ST_OUT;
        end else begin
          state_d = ST_C_RD;
        end
      end
      ST_SEL_RD:  state_d = ST_SEL_OFF;
      ST_SEL_OFF: state_d = ST_MULX;
      ST_MULX:    state_d = ST_MULY;
      ST_MULY:    state_d = ST_DIV_GO;
      ST_DIV_GO:  state_d = ST_DIV;
      ST_DIV: begin
        if (div_done_x && div_done_y) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN:     state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_axis_tready_o = 1'b0;
    div_start       = 1'b0;
    case (state_q)
      ST_IDLE:   s_axis_tready_o = 1'b1;
      ST_DIV_GO: div_start       = 1'b1;
      default: begin
        s_axis_tready_o = 1'b0;
        div_start       = 1'b0;
      end
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          dir_q        <= (in_op == OP_LOGIC_TO_PHYS);
          px_q         <= {in_px[CB-1], in_px};
          py_q         <= {in_py[CB-1], in_py};
          ptr_q        <= '0;
          closed_hit_q <= 1'b0;
          res_found_q  <= 1'b0;
          res_idx_q    <= '0;
          res_x_q      <= '0;
          res_y_q      <= '0;
        end
      end
      ST_A_CHK: begin
        if (a_hit) begin
          sel_q <= ptr_q;
          cx_q  <= px_q;
          cy_q  <= py_q;
        end else begin
          ptr_q <= last ? '0 : ptr_q + AW'(1);
        end
      end
      ST_B_CLAMP: begin
        clx_q <= clx;
        cly_q <= cly;
        ax_q  <= dx[CB+1] ? (CB+1)'(-dx) : dx[CB:0];
        ay_q  <= dy[CB+1] ? (CB+1)'(-dy) : dy[CB:0];
      end
      ST_B_SQX: sqx_q <= ax_q * ax_q;
      ST_B_SQY: sqy_q <= ay_q * ay_q;
      ST_B_CMP: begin
        // Keep the nearest entry; the earlier one wins a tie
        if (ptr_q == '0 || dist_sum < best_q) begin
          best_q <= dist_sum;
          cx_q   <= clx_q;
          cy_q   <= cly_q;
        end
        ptr_q <= last ? '0 : ptr_q + AW'(1);
      end
      ST_C_CHK: begin
        if (c_open) begin
          sel_q <= ptr_q;
        end else begin
          if (c_closed && !closed_hit_q) begin
            closed_hit_q <= 1'b1;
            closed_i_q   <= ptr_q;
          end
          if (last) begin
            sel_q <= closed_hit_q ? closed_i_q : ptr_q;
            ptr_q <= closed_hit_q ? closed_i_q : ptr_q;
          end else begin
            ptr_q <= ptr_q + AW'(1);
          end
        end
      end
      ST_SEL_OFF: begin
        offx_q  <= offx_w[CB-2:0];
        offy_q  <= offy_w[CB-2:0];
        numx_q  <= rec_w(rec_dst);
        numy_q  <= rec_h(rec_dst);
        denx_q  <= rec_w(rec_src);
        deny_q  <= rec_h(rec_src);
        basex_q <= dst_x[CB-1:0];
        basey_q <= dst_y[CB-1:0];
      end
      ST_MULX: prodx_q <= offx_q * numx_q;
      ST_MULY: prody_q <= offy_q * numy_q;
      ST_FIN: begin
        res_found_q <= 1'b1;
        res_idx_q   <= 2'(sel_q);
        res_x_q     <= finish(basex_q, quot_x, rem_x);
        res_y_q     <= finish(basey_q, quot_y, rem_y);
      end
      default: begin
      end
    endcase
  end

  // Offset times size ratio, one divider per axis
  mrcm_div #(
    .NUM_W(ProdW),
    .DEN_W(CB-1)
  ) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (prodx_q),
    .den_i  (denx_q),
    .done_o (div_done_x),
    .quot_o (quot_x),
    .rem_o  (rem_x)
  );

  mrcm_div #(
    .NUM_W(ProdW),
    .DEN_W(CB-1)
  ) u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (prody_q),
    .den_i  (deny_q),
    .done_o (div_done_y),
    .quot_o (quot_y),
    .rem_o  (rem_y)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import mrcm_pkg::*;

  localparam int unsigned NPANEL   = 4;
  localparam longint      COORD_HI = 64'sd8388607;
  localparam longint      COORD_LO = -64'sd8388608;
  localparam int          WDOG_MAX = 6000;
  localparam int          HOLD_LEN = 400;
  localparam int          SETTLE   = 120;

  typedef struct {
    op_e                op;
    logic [1:0]         idx;
    logic signed [23:0] rx;
    logic signed [23:0] ry;
    logic [22:0]        rw;
    logic [22:0]        rh;
    logic signed [23:0] px;
    logic signed [23:0] py;
  } beat_in_t;

  typedef struct {
    bit                 found;
    logic [1:0]         panel;
    logic signed [23:0] mx;
    logic signed [23:0] my;
  } mapping_t;

  typedef struct {
    int       cfg;      // panel count written before the row, -1 for none
    beat_in_t it;
    bit       typed;
    mapping_t want;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_wdata_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [143:0] s_axis_tdata_i = '0;
  logic [1:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [55:0]  m_axis_tdata_o;
  logic         m_axis_tuser_o;

  multi_rect_coordinate_mapper_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #10 clk_i = ~clk_i;

  // Mirror of the panel table and count
  longint   phys_org[NPANEL][2];
  longint   phys_len[NPANEL][2];
  longint   log_org[NPANEL][2];
  longint   log_len[NPANEL][2];
  int       panels_used;

  mapping_t mapping_q[$];
  int       errors, n_sent, n_checked, n_found, n_sat;
  int       send_idle, recv_stall;
  bit       hold_req, hold_done;
  int       wdog;

  function automatic longint min_one(longint s);
    return (s < 1) ? 64'sd1 : s;
  endfunction

  function automatic bit covers(longint ox, longint oy, longint sx, longint sy,
                                longint px, longint py, bit closed);
    longint r, b;
    r = ox + min_one(sx);
    b = oy + min_one(sy);
    if (px < ox || py < oy) return 1'b0;
    if (closed) return (px <= r) && (py <= b);
    return (px < r) && (py < b);
  endfunction

  function automatic longint clamp_to(longint v, longint lo, longint len);
    longint hi;
    hi = lo + min_one(len);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint dist_sq(int i, longint px, longint py);
    longint dx, dy;
    dx = clamp_to(px, phys_org[i][0], phys_len[i][0]) - px;
    dy = clamp_to(py, phys_org[i][1], phys_len[i][1]) - py;
    return dx * dx + dy * dy;
  endfunction

  // Truncate toward zero, then saturate to the coordinate range
  function automatic logic signed [23:0] rescale(longint base, longint off,
                                                 longint num, longint den);
    longint q;
    q = (base * den + off * num) / den;
    if (q > COORD_HI) begin
      n_sat++;
      q = COORD_HI;
    end else if (q < COORD_LO) begin
      n_sat++;
      q = COORD_LO;
    end
    return q[23:0];
  endfunction

  // Work out the result of one beat and update the table mirror
  function automatic mapping_t map_point(beat_in_t it);
    mapping_t r;
    longint   px, py, cx, cy, bd, d;
    int       sel, best;
    bit       hit_any;
    r = '{default: '0};
    px = it.px;
    py = it.py;
    sel = -1;
    if (it.op == OP_LOAD_PHYS || it.op == OP_LOAD_LOGIC) begin
      if (it.op == OP_LOAD_PHYS) begin
        phys_org[it.idx][0] = it.rx;
        phys_org[it.idx][1] = it.ry;
        phys_len[it.idx][0] = min_one(longint'(it.rw));
        phys_len[it.idx][1] = min_one(longint'(it.rh));
      end else begin
        log_org[it.idx][0] = it.rx;
        log_org[it.idx][1] = it.ry;
        log_len[it.idx][0] = min_one(longint'(it.rw));
        log_len[it.idx][1] = min_one(longint'(it.rh));
      end
      return r;
    end
    if (it.op == OP_PHYS_TO_LOGIC) begin
      cx = px;
      cy = py;
      hit_any = 1'b0;
      for (int i = 0; i < panels_used && !hit_any; i++)
        hit_any = covers(phys_org[i][0], phys_org[i][1], phys_len[i][0], phys_len[i][1],
                         px, py, 1'b0);
      // clamp onto the nearest entry, first one wins a tie
      if (panels_used > 0 && !hit_any) begin
        best = 0;
        bd = dist_sq(0, px, py);
        for (int i = 1; i < panels_used; i++) begin
          d = dist_sq(i, px, py);
          if (d < bd) begin
            bd = d;
            best = i;
          end
        end
        cx = clamp_to(px, phys_org[best][0], phys_len[best][0]);
        cy = clamp_to(py, phys_org[best][1], phys_len[best][1]);
      end
      for (int i = 0; i < panels_used && sel < 0; i++)
        if (covers(phys_org[i][0], phys_org[i][1], phys_len[i][0], phys_len[i][1],
                   cx, cy, 1'b0)) sel = i;
      // outer edge: fall back to the closed rectangle
      for (int i = 0; i < panels_used && sel < 0; i++)
        if (covers(phys_org[i][0], phys_org[i][1], phys_len[i][0], phys_len[i][1],
                   cx, cy, 1'b1)) sel = i;
      if (sel >= 0) begin
        r.mx = rescale(log_org[sel][0], cx - phys_org[sel][0], log_len[sel][0],
                       phys_len[sel][0]);
        r.my = rescale(log_org[sel][1], cy - phys_org[sel][1], log_len[sel][1],
                       phys_len[sel][1]);
      end
    end else begin
      for (int i = 0; i < panels_used && sel < 0; i++)
        if (covers(log_org[i][0], log_org[i][1], log_len[i][0], log_len[i][1],
                   px, py, 1'b0)) sel = i;
      if (sel >= 0) begin
        r.mx = rescale(phys_org[sel][0], px - log_org[sel][0], phys_len[sel][0],
                       log_len[sel][0]);
        r.my = rescale(phys_org[sel][1], py - log_org[sel][1], phys_len[sel][1],
                       log_len[sel][1]);
      end
    end
    if (sel >= 0) begin
      r.found = 1'b1;
      r.panel = sel[1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Offer one beat; valid stays high afterwards unless a gap follows
  task automatic send_beat(beat_in_t it);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= it.op;
    s_axis_tdata_i  <= {it.py, it.px, it.rh, it.rw, it.ry, it.rx, it.idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    mapping_q.push_back(map_point(it));
    n_sent++;
  endtask

  task automatic send_checked(beat_in_t it, mapping_t want);
    mapping_t got;
    send_beat(it);
    got = mapping_q[$];
    if (got.found != want.found)
      report_mismatch("directed row found", got.found, want.found);
    if (got.panel != want.panel)
      report_mismatch("directed row panel_index", got.panel, want.panel);
    if (got.mx != want.mx)
      report_mismatch("directed row mapped_x", got.mx, want.mx);
    if (got.my != want.my)
      report_mismatch("directed row mapped_y", got.my, want.my);
  endtask

  // Drain all results, let the block settle, then write the count
  task automatic write_count(int v);
    s_axis_tvalid_i <= 1'b0;
    wait (mapping_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[2:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    panels_used = (v > NPANEL) ? NPANEL : v;
  endtask

  function automatic logic [22:0] pick_len();
    case ($urandom_range(9))
      0:       return 23'd0;
      1:       return 23'h7fffff;
      2:       return 23'($urandom);
      default: return 23'($urandom_range(1, 8192));
    endcase
  endfunction

  function automatic logic signed [23:0] pick_org();
    if ($urandom_range(7) == 0) return 24'($urandom);
    return 24'(int'($urandom_range(0, 40000)) - 20000);
  endfunction

  // Coordinate around a span: edges, inside, or a little outside
  function automatic logic signed [23:0] near(longint org, longint len);
    longint v, m;
    m = len / 4 + 2;
    case ($urandom_range(5))
      0:       v = org;
      1:       v = org + len;
      2:       v = org + len - 1;
      default: v = org - m + longint'($urandom_range(0, 32'(len + 2 * m)));
    endcase
    if (v > COORD_HI) v = COORD_HI;
    if (v < COORD_LO) v = COORD_LO;
    return v[23:0];
  endfunction

  function automatic beat_in_t random_beat();
    beat_in_t it;
    int       j;
    it.op  = op_e'($urandom_range(3));
    it.idx = 2'($urandom);
    it.rx  = 24'($urandom);
    it.ry  = 24'($urandom);
    it.rw  = 23'($urandom);
    it.rh  = 23'($urandom);
    it.px  = 24'($urandom);
    it.py  = 24'($urandom);
    if ($urandom_range(9) == 0) return it;
    // mostly queries that land near a table entry
    if ($urandom_range(9) < 2) begin
      it.op = ($urandom_range(1) != 0) ? OP_LOAD_PHYS : OP_LOAD_LOGIC;
      it.rx = pick_org();
      it.ry = pick_org();
      it.rw = pick_len();
      it.rh = pick_len();
    end else begin
      it.op = ($urandom_range(1) != 0) ? OP_PHYS_TO_LOGIC : OP_LOGIC_TO_PHYS;
      j = $urandom_range(NPANEL - 1);
      if (it.op == OP_PHYS_TO_LOGIC) begin
        it.px = near(phys_org[j][0], phys_len[j][0]);
        it.py = near(phys_org[j][1], phys_len[j][1]);
      end else begin
        it.px = near(log_org[j][0], log_len[j][0]);
        it.py = near(log_org[j][1], log_len[j][1]);
      end
    end
    return it;
  endfunction

  function automatic beat_in_t mk(op_e op, int idx, int rx, int ry, int rw, int rh,
                                  int px, int py);
    beat_in_t it;
    it.op = op;
    it.idx = idx[1:0];
    it.rx = rx[23:0];
    it.ry = ry[23:0];
    it.rw = rw[22:0];
    it.rh = rh[22:0];
    it.px = px[23:0];
    it.py = py[23:0];
    return it;
  endfunction

  // Receiver: random back-pressure plus one long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        for (int k = 0; k < HOLD_LEN; k++) begin
          m_axis_tready_i <= 1'b0;
          @(posedge clk_i);
        end
        hold_done = 1'b1;
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (mapping_q.size() == 0) begin
        report_mismatch("result beats beyond those expected", 1, 0);
      end else begin
        mapping_t want;
        want = mapping_q.pop_front();
        if (m_axis_tuser_o !== want.found)
          report_mismatch("found", m_axis_tuser_o, want.found);
        if (m_axis_tdata_o[1:0] !== want.panel)
          report_mismatch("panel_index", m_axis_tdata_o[1:0], want.panel);
        if ($signed(m_axis_tdata_o[25:2]) !== want.mx)
          report_mismatch("mapped_x", $signed(m_axis_tdata_o[25:2]), want.mx);
        if ($signed(m_axis_tdata_o[49:26]) !== want.my)
          report_mismatch("mapped_y", $signed(m_axis_tdata_o[49:26]), want.my);
        n_checked++;
        if (want.found) n_found++;
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      wdog <= 0;
    else
      wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("Timeout: no beat moved for %0d cycles", WDOG_MAX);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    mapping_t none;
    int       counts[9] = '{1, 2, 3, 4, 7, 5, 0, 4, 6};
    int       stall_tab[4][2] = '{'{0, 0}, '{59, 0}, '{0, 59}, '{24, 24}};

    errors = 0; n_sent = 0; n_checked = 0; n_found = 0; n_sat = 0;
    wdog = 0; hold_req = 0; hold_done = 0;
    send_idle = 0; recv_stall = 0; panels_used = 0;
    none = '{default: '0};
    for (int i = 0; i < NPANEL; i++) begin
      phys_org[i] = '{0, 0}; phys_len[i] = '{1, 1};
      log_org[i] = '{0, 0};  log_len[i] = '{1, 1};
    end

    // Directed rows: empty table, loads, then edge and extreme queries
    rows.push_back('{-1, mk(OP_PHYS_TO_LOGIC, 0, 0, 0, 0, 0, 100, 100), 1, none});
    rows.push_back('{-1, mk(OP_LOGIC_TO_PHYS, 3, -1, -1, 0, 0, -8388608, 8388607), 1, none});
    rows.push_back('{-1, mk(OP_LOAD_PHYS, 0, 0, 0, 25600, 25600, 0, 0), 1, none});
    rows.push_back('{-1, mk(OP_LOAD_LOGIC, 0, 0, 0, 491520, 276480, 0, 0), 1, none});
    rows.push_back('{-1, mk(OP_LOAD_PHYS, 1, 25600, 0, 25600, 25600, 0, 0), 1, none});
    rows.push_back('{-1, mk(OP_LOAD_LOGIC, 1, 491520, 0, 327680, 184320, 0, 0), 1, none});
    rows.push_back('{-1, mk(OP_LOAD_PHYS, 2, -1000, -1000, 0, 0, 0, 0), 1, none});
    rows.push_back('{-1, mk(OP_LOAD_LOGIC, 2, -5000, -5000, 0, 0, 0, 0), 1, none});
    rows.push_back('{-1, mk(OP_LOAD_PHYS, 3, -8388608, -8388608, 1, 1, 0, 0), 1, none});
    rows.push_back('{-1, mk(OP_LOAD_LOGIC, 3, 8388607, 8388607, 8388607, 8388607, 0, 0),
                     1, none});
    rows.push_back('{4, mk(OP_PHYS_TO_LOGIC, 0, 0, 0, 0, 0, 100, 100), 0, none});
    rows.push_back('{-1, mk(OP_PHYS_TO_LOGIC, 0, 0, 0, 0, 0, 25600, 50), 0, none});
    rows.push_back('{-1, mk(OP_PHYS_TO_LOGIC, 0, 0, 0, 0, 0, 51200, 25600), 0, none});
    rows.push_back('{-1, mk(OP_PHYS_TO_LOGIC, 0, 0, 0, 0, 0, 90000, 90000), 0, none});
    rows.push_back('{-1, mk(OP_PHYS_TO_LOGIC, 0, 0, 0, 0, 0, -8388608, -8388608), 0, none});
    rows.push_back('{-1, mk(OP_PHYS_TO_LOGIC, 0, 0, 0, 0, 0, -1000, -1000), 0, none});
    rows.push_back('{-1, mk(OP_PHYS_TO_LOGIC, 0, 0, 0, 0, 0, 8388607, -8388608), 0, none});
    rows.push_back('{-1, mk(OP_LOGIC_TO_PHYS, 0, 0, 0, 0, 0, 491519, 276479), 0, none});
    rows.push_back('{-1, mk(OP_LOGIC_TO_PHYS, 0, 0, 0, 0, 0, 491520, 100), 0, none});
    rows.push_back('{-1, mk(OP_LOGIC_TO_PHYS, 0, 0, 0, 0, 0, 8388607, 8388607), 0, none});
    rows.push_back('{-1, mk(OP_LOGIC_TO_PHYS, 0, 0, 0, 0, 0, -8388608, -8388608), 1, none});
    rows.push_back('{-1, mk(OP_LOGIC_TO_PHYS, 0, 0, 0, 0, 0, -5000, -5000), 0, none});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Walk the directed table
    foreach (rows[i]) begin
      if (rows[i].cfg >= 0) write_count(rows[i].cfg);
      if (rows[i].typed) send_checked(rows[i].it, rows[i].want);
      else send_beat(rows[i].it);
    end

    // Random phases across panel counts and idling patterns
    foreach (counts[p]) begin
      write_count(counts[p]);
      send_idle  = stall_tab[p % 4][0];
      recv_stall = stall_tab[p % 4][1];
      if (p == 3) hold_req = 1'b1;
      for (int k = 0; k < 117; k++) send_beat(random_beat());
    end

    s_axis_tvalid_i <= 1'b0;
    wait (mapping_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);

    $display("Sent %0d beats over panel counts 0 to 7 with four idling patterns;",
             n_sent);
    $display("checked %0d results, %0d mapped, %0d saturated coordinates predicted.",
             n_checked, n_found, n_sat);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
